### rtl/assert_macros.svh
// Assertion macros for RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHECK_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/mfms_pkg.sv
// Types and constants shared by the fast magnetosonic speed pipeline.
package mfms_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned GAMMA_W = 24;
  localparam int unsigned FRAC_W  = 20;
  localparam int unsigned ADDR_W  = 3;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd1747627;

  // Register index, taken from the word-address bit of paddr.
  localparam logic REG_ADIABATIC_INDEX = 1'b0;

  // The three quotients share one divisor; each lane retires one bit per stage.
  localparam int unsigned LANES = 3;
  localparam int unsigned DIV_W = 63;

  // Sum of a2 and b2 below the saturation limit, and the products built on it.
  localparam int unsigned SUM_W  = 45;
  localparam int unsigned LO_W   = 32;
  localparam int unsigned SSQ_W  = 2 * SUM_W;
  localparam int unsigned PROD_W = SUM_W + DIV_W;

  // Root chains: discriminant root, then the root of the squared speed.
  localparam int unsigned SQ1_N    = SUM_W;
  localparam int unsigned SQ2_N    = DATA_W + 1;
  localparam int unsigned SQ_SHIFT = 19;

  // Clock edges from the accepting edge to the edge that samples done high.
  localparam int unsigned RESULT_LATENCY = DIV_W + SQ1_N + SQ2_N + 8;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_ZERO_DENSITY = 2'd1,
    STATUS_SATURATED    = 2'd2
  } status_t;

  typedef struct packed {
    logic zero;
    logic sat;
    logic last;
  } side_t;

endpackage

### rtl/mfms_div.sv
// Pipelined restoring divider: three dividends over one divisor, one quotient bit per stage.
module mfms_div (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  input  mfms_pkg::side_t                                in_side,
  input  logic [mfms_pkg::DATA_W-1:0]                    divisor,
  input  logic [mfms_pkg::LANES-1:0][mfms_pkg::DIV_W-1:0] dividend,
  output logic                                           out_valid,
  output mfms_pkg::side_t                                out_side,
  output logic [mfms_pkg::LANES-1:0][mfms_pkg::DIV_W-1:0] quotient
);

  localparam int unsigned W  = mfms_pkg::DIV_W;
  localparam int unsigned DW = mfms_pkg::DATA_W;
  localparam int unsigned NL = mfms_pkg::LANES;

  logic                       vld  [W];
  mfms_pkg::side_t            side [W];
  logic [DW-1:0]              dsr  [W];
  logic [NL-1:0][DW-1:0]      rem  [W];
  logic [NL-1:0][W-1:0]       num  [W];

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic                  p_vld;
    mfms_pkg::side_t       p_side;
    logic [DW-1:0]         p_dsr;
    logic [NL-1:0][DW-1:0] p_rem;
    logic [NL-1:0][W-1:0]  p_num;
    logic [NL-1:0][DW:0]   trial;
    logic [NL-1:0][DW:0]   diff;
    logic [NL-1:0][DW-1:0] rem_next;
    logic [NL-1:0][W-1:0]  num_next;

    if (g == 0) begin : g_head
      assign p_vld  = in_valid;
      assign p_side = in_side;
      assign p_dsr  = divisor;
      assign p_rem  = '0;
      assign p_num  = dividend;
    end else begin : g_body
      assign p_vld  = vld[g-1];
      assign p_side = side[g-1];
      assign p_dsr  = dsr[g-1];
      assign p_rem  = rem[g-1];
      assign p_num  = num[g-1];
    end

    // The partial remainder stays below the divisor, so it fits DW bits.
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        trial[l] = {p_rem[l], p_num[l][W-1]};
        diff[l]  = trial[l] - {1'b0, p_dsr};
        if (trial[l] >= {1'b0, p_dsr}) begin
          rem_next[l] = diff[l][DW-1:0];
          num_next[l] = {p_num[l][W-2:0], 1'b1};
        end else begin
          rem_next[l] = trial[l][DW-1:0];
          num_next[l] = {p_num[l][W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= p_vld;
      end
      side[g] <= p_side;
      dsr[g]  <= p_dsr;
      rem[g]  <= rem_next;
      num[g]  <= num_next;
    end
  end

  assign out_valid = vld[W-1];
  assign out_side  = side[W-1];
  assign quotient  = num[W-1];

endmodule

### rtl/mfms_root.sv
// Two chained pipelined square roots: the discriminant root, then the speed root.
module mfms_root (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  mfms_pkg::side_t                  in_side,
  input  logic [mfms_pkg::SUM_W-1:0]       sum,
  input  logic [mfms_pkg::SSQ_W-1:0]       disc,
  output logic                             out_valid,
  output mfms_pkg::side_t                  out_side,
  output logic [mfms_pkg::SQ2_N-1:0]       root
);

  localparam int unsigned N1 = mfms_pkg::SQ1_N;
  localparam int unsigned N2 = mfms_pkg::SQ2_N;
  localparam int unsigned SW = mfms_pkg::SUM_W;

  // First root: floor sqrt of the Q.40 discriminant.
  logic              v1   [N1];
  mfms_pkg::side_t   sd1  [N1];
  logic [SW-1:0]     s1   [N1];
  logic [2*N1-1:0]   rad1 [N1];
  logic [N1+1:0]     rem1 [N1];
  logic [N1-1:0]     rt1  [N1];

  for (genvar g = 0; g < N1; g++) begin : g_sq1
    logic            p_vld;
    mfms_pkg::side_t p_side;
    logic [SW-1:0]   p_s;
    logic [2*N1-1:0] p_rad;
    logic [N1+1:0]   p_rem;
    logic [N1-1:0]   p_rt;
    logic [N1+3:0]   remx;
    logic [N1+3:0]   trial;
    logic [N1+3:0]   diff;
    logic [N1+1:0]   rem_next;
    logic [N1-1:0]   rt_next;

    if (g == 0) begin : g_head
      assign p_vld  = in_valid;
      assign p_side = in_side;
      assign p_s    = sum;
      assign p_rad  = disc;
      assign p_rem  = '0;
      assign p_rt   = '0;
    end else begin : g_body
      assign p_vld  = v1[g-1];
      assign p_side = sd1[g-1];
      assign p_s    = s1[g-1];
      assign p_rad  = rad1[g-1];
      assign p_rem  = rem1[g-1];
      assign p_rt   = rt1[g-1];
    end

    always_comb begin
      remx  = {p_rem, p_rad[2*N1-1 -: 2]};
      trial = {2'b00, p_rt, 2'b01};
      diff  = remx - trial;
      if (remx >= trial) begin
        rem_next = diff[N1+1:0];
        rt_next  = {p_rt[N1-2:0], 1'b1};
      end else begin
        rem_next = remx[N1+1:0];
        rt_next  = {p_rt[N1-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v1[g] <= 1'b0;
      end else begin
        v1[g] <= p_vld;
      end
      sd1[g]  <= p_side;
      s1[g]   <= p_s;
      rad1[g] <= {p_rad[2*N1-3:0], 2'b00};
      rem1[g] <= rem_next;
      rt1[g]  <= rt_next;
    end
  end

  // Squared speed in Q.40: (s + r) shifted up by SQ_SHIFT.
  logic            cv;
  mfms_pkg::side_t cside;
  logic [2*N2-1:0] cx;
  logic [SW:0]     csum;

  assign csum = {1'b0, s1[N1-1]} + {1'b0, rt1[N1-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else begin
      cv <= v1[N1-1];
    end
    cside <= sd1[N1-1];
    cx    <= (2*N2)'({csum, {mfms_pkg::SQ_SHIFT{1'b0}}});
  end

  // Second root: floor sqrt of the squared speed.
  logic            v2   [N2];
  mfms_pkg::side_t sd2  [N2];
  logic [2*N2-1:0] rad2 [N2];
  logic [N2+1:0]   rem2 [N2];
  logic [N2-1:0]   rt2  [N2];

  for (genvar g = 0; g < N2; g++) begin : g_sq2
    logic            p_vld;
    mfms_pkg::side_t p_side;
    logic [2*N2-1:0] p_rad;
    logic [N2+1:0]   p_rem;
    logic [N2-1:0]   p_rt;
    logic [N2+3:0]   remx;
    logic [N2+3:0]   trial;
    logic [N2+3:0]   diff;
    logic [N2+1:0]   rem_next;
    logic [N2-1:0]   rt_next;

    if (g == 0) begin : g_head
      assign p_vld  = cv;
      assign p_side = cside;
      assign p_rad  = cx;
      assign p_rem  = '0;
      assign p_rt   = '0;
    end else begin : g_body
      assign p_vld  = v2[g-1];
      assign p_side = sd2[g-1];
      assign p_rad  = rad2[g-1];
      assign p_rem  = rem2[g-1];
      assign p_rt   = rt2[g-1];
    end

    always_comb begin
      remx  = {p_rem, p_rad[2*N2-1 -: 2]};
      trial = {2'b00, p_rt, 2'b01};
      diff  = remx - trial;
      if (remx >= trial) begin
        rem_next = diff[N2+1:0];
        rt_next  = {p_rt[N2-2:0], 1'b1};
      end else begin
        rem_next = remx[N2+1:0];
        rt_next  = {p_rt[N2-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v2[g] <= 1'b0;
      end else begin
        v2[g] <= p_vld;
      end
      sd2[g]  <= p_side;
      rad2[g] <= {p_rad[2*N2-3:0], 2'b00};
      rem2[g] <= rem_next;
      rt2[g]  <= rt_next;
    end
  end

  assign out_valid = v2[N2-1];
  assign out_side  = sd2[N2-1];
  assign root      = rt2[N2-1];

endmodule

### rtl/mhd_fast_magnetosonic_speed_top.sv
// Top level of the fast magnetosonic speed pipeline with its register port.
//
// This block computes the fast magnetosonic speed of one grid point per beat
// and takes a new beat in every clock cycle: busy is high only while rst is
// asserted. A result appears on fast_speed, status and last_out with a
// one-cycle done pulse, in the same order as the inputs; the receiver cannot
// stall and must take each result in the cycle it is shown. The pipeline is
// made of the divider, which retires one quotient bit per stage for 63
// stages, and of the two square roots, which retire one root bit per stage
// for 45 and 33 stages; further stages hold the input, the products, the sum
// with its range check, the partial products, their recombination, the
// discriminant, the squared speed and the result. All values are Q.20 fixed
// point and every division and root truncates. A point with zero density
// gives a speed of 0 with status 1; a sum a2 + b2 at or above 2^25, or a
// speed that does not fit 32 bits, gives 0xFFFFFFFF with status 2; a
// negative discriminant is taken as zero. The adiabatic index lives at byte
// address 0 of the register port, resets to five thirds, and should only be
// written while no points are in flight.
`include "assert_macros.svh"

module mhd_fast_magnetosonic_speed_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mfms_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic [mfms_pkg::DATA_W-1:0]     density,
  input  logic [mfms_pkg::DATA_W-1:0]     pressure,
  input  logic signed [mfms_pkg::DATA_W-1:0] field_normal,
  input  logic [mfms_pkg::DATA_W-1:0]     field_sq,
  input  logic                            last_in,
  output logic                            done,
  output logic [mfms_pkg::DATA_W-1:0]     fast_speed,
  output logic [1:0]                      status,
  output logic                            last_out
);

  localparam int unsigned DW    = mfms_pkg::DATA_W;
  localparam int unsigned GW    = mfms_pkg::GAMMA_W;
  localparam int unsigned QW    = mfms_pkg::DIV_W;
  localparam int unsigned SW    = mfms_pkg::SUM_W;
  localparam int unsigned LW    = mfms_pkg::LO_W;
  localparam int unsigned S_HI  = SW - LW;
  localparam int unsigned B_HI  = QW - LW;
  localparam int unsigned SSQW  = mfms_pkg::SSQ_W;
  localparam int unsigned PW    = mfms_pkg::PROD_W;

  // Register port. Writes complete in the access phase; the word-address
  // bit of paddr selects the register, so address 4 reads as zero.
  logic          cfg_write;
  logic [GW-1:0] gamma;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[mfms_pkg::ADDR_W-1] == mfms_pkg::REG_ADIABATIC_INDEX) ?
                     {{(32-GW){1'b0}}, gamma} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= mfms_pkg::GAMMA_RESET;
    end else if (cfg_write &&
                 paddr[mfms_pkg::ADDR_W-1] == mfms_pkg::REG_ADIABATIC_INDEX) begin
      gamma <= pwdata[GW-1:0];
    end
  end

  // The pipeline never stalls, so a point is taken whenever start is high outside reset.
  logic in_accept;

  assign busy      = rst;
  assign in_accept = start & ~busy;

  // Entry stage: capture the point.
  logic          e_vld;
  logic [DW-1:0] e_rho;
  logic [DW-1:0] e_p;
  logic [DW-1:0] e_bx;
  logic [DW-1:0] e_bb;
  logic          e_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= in_accept;
    end
    e_rho  <= density;
    e_p    <= pressure;
    e_bx   <= field_normal;
    e_bb   <= field_sq;
    e_last <= last_in;
  end

  // Product stage: gamma*P, field_sq shifted up and bx*bx form the dividends.
  // The most negative bx has magnitude 2^31, which still fits 32 unsigned bits.
  logic [DW-1:0]    mag;
  logic [GW+DW-1:0] gp;
  logic [2*DW-1:0]  mm;

  logic                               p_vld;
  mfms_pkg::side_t                    p_side;
  logic [DW-1:0]                      p_rho;
  logic [mfms_pkg::LANES-1:0][QW-1:0] p_div;

  assign mag = e_bx[DW-1] ? (~e_bx + 1'b1) : e_bx;
  assign gp  = gamma * e_p;
  assign mm  = mag * mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= e_vld;
    end
    p_side.zero <= (e_rho == '0);
    p_side.sat  <= 1'b0;
    p_side.last <= e_last;
    p_rho       <= e_rho;
    p_div[0]    <= QW'(gp);
    p_div[1]    <= QW'({e_bb, {mfms_pkg::FRAC_W{1'b0}}});
    p_div[2]    <= mm[QW-1:0];
  end

  // Division by density: lane 0 gives a2, lane 1 gives b2, lane 2 gives bx2.
  logic                               q_vld;
  mfms_pkg::side_t                    q_side;
  logic [mfms_pkg::LANES-1:0][QW-1:0] q;

  mfms_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_vld),
    .in_side   (p_side),
    .divisor   (p_rho),
    .dividend  (p_div),
    .out_valid (q_vld),
    .out_side  (q_side),
    .quotient  (q)
  );

  // Sum stage: s = a2 + b2 and the early saturation check. Below the limit
  // a2 also fits the sum width, so only those bits move on.
  logic [QW:0] s_full;

  logic            a_vld;
  mfms_pkg::side_t a_side;
  logic [SW-1:0]   a_s;
  logic [SW-1:0]   a_a2;
  logic [QW-1:0]   a_bx2;

  assign s_full = {1'b0, q[0]} + {1'b0, q[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= q_vld;
    end
    a_side.zero <= q_side.zero;
    a_side.sat  <= |s_full[QW:SW];
    a_side.last <= q_side.last;
    a_s         <= s_full[SW-1:0];
    a_a2        <= q[0][SW-1:0];
    a_bx2       <= q[2];
  end

  // Partial products of s*s and a2*bx2, each no wider than 32 by 32 bits.
  logic               b_vld;
  mfms_pkg::side_t    b_side;
  logic [SW-1:0]      b_s;
  logic [2*LW-1:0]    b_ss_ll;
  logic [LW+S_HI-1:0] b_ss_lh;
  logic [2*S_HI-1:0]  b_ss_hh;
  logic [2*LW-1:0]    b_ab_ll;
  logic [LW+B_HI-1:0] b_ab_lh;
  logic [S_HI+LW-1:0] b_ab_hl;
  logic [S_HI+B_HI-1:0] b_ab_hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_side  <= a_side;
    b_s     <= a_s;
    b_ss_ll <= a_s[LW-1:0] * a_s[LW-1:0];
    b_ss_lh <= a_s[LW-1:0] * a_s[SW-1:LW];
    b_ss_hh <= a_s[SW-1:LW] * a_s[SW-1:LW];
    b_ab_ll <= a_a2[LW-1:0] * a_bx2[LW-1:0];
    b_ab_lh <= a_a2[LW-1:0] * a_bx2[QW-1:LW];
    b_ab_hl <= a_a2[SW-1:LW] * a_bx2[LW-1:0];
    b_ab_hh <= a_a2[SW-1:LW] * a_bx2[QW-1:LW];
  end

  // Recombine: s*s in Q.40, and 4*a2*bx2 split into the bits that can be
  // compared against s*s and a flag for anything above them.
  logic [PW-1:0] prod;

  logic            c_vld;
  mfms_pkg::side_t c_side;
  logic [SW-1:0]   c_s;
  logic [SSQW-1:0] c_ssq;
  logic [SSQW-1:0] c_t;
  logic            c_t_big;

  assign prod = PW'(b_ab_ll) + (PW'(b_ab_lh) << LW) + (PW'(b_ab_hl) << LW) +
                (PW'(b_ab_hh) << (2*LW));

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_side  <= b_side;
    c_s     <= b_s;
    c_ssq   <= SSQW'(b_ss_ll) + (SSQW'(b_ss_lh) << (LW+1)) + (SSQW'(b_ss_hh) << (2*LW));
    c_t     <= {prod[SSQW-3:0], 2'b00};
    c_t_big <= |prod[PW-1:SSQW-2];
  end

  // Discriminant, clamped at zero when 4*a2*bx2 exceeds s*s.
  logic            d_vld;
  mfms_pkg::side_t d_side;
  logic [SW-1:0]   d_s;
  logic [SSQW-1:0] d_disc;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
    d_side <= c_side;
    d_s    <= c_s;
    d_disc <= (c_t_big || c_t > c_ssq) ? '0 : (c_ssq - c_t);
  end

  // Both square roots.
  logic                      r_vld;
  mfms_pkg::side_t           r_side;
  logic [mfms_pkg::SQ2_N-1:0] r_root;

  mfms_root u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_vld),
    .in_side   (d_side),
    .sum       (d_s),
    .disc      (d_disc),
    .out_valid (r_vld),
    .out_side  (r_side),
    .root      (r_root)
  );

  // Result register: zero density wins over saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_vld;
    end
    last_out <= r_side.last;
    priority if (r_side.zero) begin
      fast_speed <= '0;
      status     <= mfms_pkg::STATUS_ZERO_DENSITY;
    end else if (r_side.sat || r_root[DW]) begin
      fast_speed <= '1;
      status     <= mfms_pkg::STATUS_SATURATED;
    end else begin
      fast_speed <= r_root[DW-1:0];
      status     <= mfms_pkg::STATUS_OK;
    end
  end

  // Every accepted beat comes out exactly once, at a fixed distance.
  `CHECK_IMPLIES(a_latency, clk, rst, 1'b1, done == $past(in_accept, mfms_pkg::RESULT_LATENCY))
  `CHECK_IMPLIES(a_zero_density, clk, rst, done && status == mfms_pkg::STATUS_ZERO_DENSITY, fast_speed == '0)
  `CHECK_IMPLIES(a_saturated, clk, rst, done && status == mfms_pkg::STATUS_SATURATED, &fast_speed)
  `CHECK_NEXT(a_cfg_write, clk, rst, cfg_write && !paddr[mfms_pkg::ADDR_W-1], gamma == $past(pwdata[GW-1:0]))

endmodule

### verif/testbench.sv
// Self-checking testbench for the fast magnetosonic speed pipeline.
//
// Grid points are queued by a stimulus process and driven by a clocked driver
// at the falling edge. A clocked monitor samples at the rising edge. It
// predicts the speed of every accepted beat in wide integer arithmetic and
// queues that prediction. It then checks each done pulse against the oldest
// prediction, field by field. The adiabatic index is rewritten between
// phases, only once the pipeline has drained, and covers its reset value,
// zero, its maximum, one and a random value. The directed points cover the
// special cases: zero density, extreme fields, a negative discriminant, a
// saturated sum and a speed that does not fit 32 bits.
module testbench;

  typedef struct {
    logic [31:0] rho;
    logic [31:0] pres;
    logic [31:0] bx;
    logic [31:0] bsq;
    logic        last;
  } point_t;

  typedef struct {
    logic [31:0]       speed;
    mfms_pkg::status_t stat;
    logic              last;
  } speed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mfms_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [31:0] density = '0;
  logic [31:0] pressure = '0;
  logic signed [31:0] field_normal = '0;
  logic [31:0] field_sq = '0;
  logic last_in = 1'b0;
  logic done;
  logic [31:0] fast_speed;
  logic [1:0] status;
  logic last_out;

  point_t points_q[$];
  speed_t speeds_q[$];
  logic [mfms_pkg::GAMMA_W-1:0] gamma_now = mfms_pkg::GAMMA_RESET;
  int gap_left = 0;
  bit steady = 0;
  int mismatches = 0;
  int checked = 0;
  int zero_seen = 0;
  int sat_seen = 0;

  mhd_fast_magnetosonic_speed_top u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .density(density), .pressure(pressure),
    .field_normal(field_normal), .field_sq(field_sq), .last_in(last_in),
    .done(done), .fast_speed(fast_speed), .status(status), .last_out(last_out)
  );

  always #5 clk = ~clk;

  // Floor of the square root of a wide value.
  function automatic logic [63:0] int_sqrt(logic [127:0] x);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= x) root = cand;
    end
    return root;
  endfunction

  function automatic speed_t fast_speed_of(point_t p, logic [mfms_pkg::GAMMA_W-1:0] g);
    speed_t r;
    logic [127:0] mag, a2, b2, bx2, s, ssq, t4, disc, rt, sq;
    r.last = p.last;
    r.speed = '0;
    r.stat = mfms_pkg::STATUS_OK;
    if (p.rho == 0) begin
      r.stat = mfms_pkg::STATUS_ZERO_DENSITY;
      return r;
    end
    mag = p.bx[31] ? (128'd1 << 32) - p.bx : p.bx;
    a2 = (128'(g) * p.pres) / p.rho;
    b2 = (128'(p.bsq) << 20) / p.rho;
    bx2 = (mag * mag) / p.rho;
    s = a2 + b2;
    if (s >= (128'd1 << 45)) begin
      r.stat = mfms_pkg::STATUS_SATURATED;
    end else begin
      ssq = s * s;
      t4 = (a2 * bx2) << 2;
      // A negative discriminant is clamped to zero.
      disc = (t4 <= ssq) ? ssq - t4 : '0;
      rt = int_sqrt(disc);
      sq = int_sqrt((s + rt) << 19);
      if (sq > 128'hFFFF_FFFF) r.stat = mfms_pkg::STATUS_SATURATED;
      else r.speed = sq[31:0];
    end
    if (r.stat == mfms_pkg::STATUS_SATURATED) r.speed = '1;
    return r;
  endfunction

  // Driver: one beat offered per cycle, with random bursts of idle cycles while steady is clear.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (points_q.size() > 0 && !steady && $urandom_range(0, 15) == 0) begin
      gap_left <= $urandom_range(0, 10);
      start <= 1'b0;
    end else if (points_q.size() > 0) begin
      density <= points_q[0].rho;
      pressure <= points_q[0].pres;
      field_normal <= points_q[0].bx;
      field_sq <= points_q[0].bsq;
      last_in <= points_q[0].last;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict on acceptance, check on done.
  always @(posedge clk) begin
    speed_t want;
    if (!rst) begin
      if (start && !busy && points_q.size() > 0) begin
        speeds_q.push_back(fast_speed_of(points_q[0], gamma_now));
        void'(points_q.pop_front());
      end
      if (done) begin
        if (speeds_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: speed %h", fast_speed);
        end else begin
          want = speeds_q.pop_front();
          checked++;
          if (want.stat == mfms_pkg::STATUS_ZERO_DENSITY) zero_seen++;
          if (want.stat == mfms_pkg::STATUS_SATURATED) sat_seen++;
          if (fast_speed !== want.speed || status !== want.stat || last_out !== want.last)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: speed %h/%h status %0d/%0d last %b/%b (exp/got)",
                       want.speed, fast_speed, want.stat, status, want.last, last_out);
          end
        end
      end
    end
  end

  task automatic add_point(logic [31:0] rho, logic [31:0] pres, logic [31:0] bx,
                           logic [31:0] bsq, logic last);
    point_t p;
    p.rho = rho;
    p.pres = pres;
    p.bx = bx;
    p.bsq = bsq;
    p.last = last;
    points_q.push_back(p);
  endtask

  // Mostly physical points with random content, some full-range noise and some with zero density.
  task automatic add_random_point();
    logic [31:0] bx;
    case ($urandom_range(0, 9))
      0, 1: add_point($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      2: add_point('0, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      default: begin
        bx = $urandom_range(0, 1 << 23);
        if ($urandom_range(0, 1)) bx = -bx;
        add_point($urandom_range(1 << 14, 1 << 26), $urandom_range(0, 1 << 26), bx,
                  32'((64'(bx[31] ? -bx : bx) ** 2) >> 20) + $urandom_range(0, 1 << 22),
                  $urandom_range(0, 7) == 0);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (points_q.size() > 0 || speeds_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic write_gamma(logic [mfms_pkg::GAMMA_W-1:0] g);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {mfms_pkg::REG_ADIABATIC_INDEX, 2'b00};
    pwdata <= {8'($urandom_range(0, 255)), g};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    gamma_now = g;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[mfms_pkg::GAMMA_W-1:0] !== g) begin
      mismatches++;
      if (mismatches <= 10) $display("register read back %h, wrote %h", prdata, g);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [mfms_pkg::GAMMA_W-1:0] settings[5];
    settings = '{24'd0, 24'hFFFFFF, 24'd1 << 20, 24'd1, 24'(($urandom))};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed points at the reset value of the adiabatic index.
    add_point('0, '1, 32'h8000_0000, '1, 1'b1);
    add_point('0, '0, '0, '0, 1'b0);
    add_point(32'd1, '1, 32'h7FFF_FFFF, '1, 1'b0);
    add_point(32'd1, '0, '0, '0, 1'b1);
    add_point('1, '1, 32'h8000_0000, '1, 1'b0);
    add_point('1, '0, '0, '0, 1'b0);
    add_point(32'd1 << 20, 32'd1 << 20, 32'd1 << 20, 32'd1 << 20, 1'b0);
    add_point(32'd1 << 20, 32'd3 << 20, -(32'd2 << 20), 32'd4 << 20, 1'b1);
    // No transverse field and a strong normal one: negative discriminant.
    add_point(32'd1 << 20, 32'd1 << 16, 32'd8 << 20, '0, 1'b0);
    add_point(32'd1 << 18, 32'd1 << 10, -(32'd1 << 26), '0, 1'b0);
    // Sum just under the limit, speed too large for 32 bits.
    add_point(32'd1, '0, '0, (32'd1 << 25) - 1, 1'b0);
    // Sum at the limit, and well past it.
    add_point(32'd1, '0, '0, 32'd1 << 25, 1'b0);
    add_point(32'd1, '1, '1, '1, 1'b1);
    add_point(32'd1, '0, '0, 32'd1 << 23, 1'b0);
    add_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    repeat (4) add_random_point();
    wait_drained();

    foreach (settings[i]) begin
      write_gamma(settings[i]);
      if (i == 4) steady = 1;
      repeat (200) add_random_point();
      wait_drained();
    end
    write_gamma(mfms_pkg::GAMMA_RESET);
    repeat (20) add_random_point();
    wait_drained();
    repeat (mfms_pkg::RESULT_LATENCY + 20) @(posedge clk);

    $display("checked %0d results (%0d zero density, %0d saturated) over 7 index settings",
             checked, zero_seen, sat_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && speeds_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
